FILE: hw/rtl/msr_pkg.sv
// msr_pkg: shared types and constants for the sample relocator
// holds config, header and result structs, register indexes and status codes
// no dependencies
package msr_pkg;

  // card and file position width
  localparam int unsigned AddrBits = 24;
  // working width for position math, wide enough that no sum overflows
  localparam int unsigned CalcBits = (AddrBits > 24) ? AddrBits + 2 : 26;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [7:0] FinetuneMask = 8'h0F;
  localparam logic [7:0] VolumeMax = 8'd64;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_FILE_SIZE         = 3'd0,
    REG_SAMPLE_DATA_START = 3'd1,
    REG_RAM_SIZE          = 3'd2,
    REG_DEST_BASE         = 3'd3,
    REG_NULL_LOOP_ADDRESS = 3'd4,
    REG_FIFTEEN_MODE      = 3'd5
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_ABORTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [23:0] file_size;
    logic [23:0] sample_data_start;
    logic [23:0] ram_size;
    logic [23:0] dest_base;
    logic [23:0] null_loop_address;
    logic        fifteen_sample_mode;
  } cfg_t;

  typedef struct packed {
    logic        first_sample;
    logic [15:0] length_words;
    logic [7:0]  finetune_byte;
    logic [7:0]  volume_byte;
    logic [15:0] loop_offset_raw;
    logic [15:0] loop_length_words;
  } header_t;

  typedef struct packed {
    logic [23:0] sample_address;
    logic [15:0] length_out_words;
    logic [23:0] loop_address;
    logic [15:0] loop_length_out;
    logic [3:0]  finetune;
    logic [6:0]  volume;
    logic [23:0] source_offset;
    logic [16:0] copy_bytes;
    logic        truncated;
    status_e     status;
    logic [23:0] bytes_used;
  } result_t;

endpackage

FILE: hw/rtl/msr_cfg_regs.sv
// msr_cfg_regs: configuration register file of the sample relocator
// write-only registers with their reset values; uses msr_pkg
module msr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [msr_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output msr_pkg::cfg_t                   cfg_o
);
  import msr_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.file_size           <= 24'd0;
      cfg_q.sample_data_start   <= 24'd1084;
      cfg_q.ram_size            <= 24'd524288;
      cfg_q.dest_base           <= 24'd2;
      cfg_q.null_loop_address   <= 24'd0;
      cfg_q.fifteen_sample_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_FILE_SIZE:         cfg_q.file_size           <= cfg_wdata_i;
        REG_SAMPLE_DATA_START: cfg_q.sample_data_start   <= cfg_wdata_i;
        REG_RAM_SIZE:          cfg_q.ram_size            <= cfg_wdata_i;
        REG_DEST_BASE:         cfg_q.dest_base           <= cfg_wdata_i;
        REG_NULL_LOOP_ADDRESS: cfg_q.null_loop_address   <= cfg_wdata_i;
        REG_FIFTEEN_MODE:      cfg_q.fifteen_sample_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/msr_in_reg.sv
// msr_in_reg: input register of the sample relocator
// captures one header request and holds it until the core takes it; uses msr_pkg
module msr_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  msr_pkg::header_t hdr_i,
  input  logic             core_ready_i,
  output logic             hdr_valid_o,
  output msr_pkg::header_t hdr_o
);
  import msr_pkg::*;

  logic    valid_q;
  header_t hdr_q;
  logic    take;
  logic    accept;

  // the core consumes the held request when its result slot frees up
  assign take       = valid_q && core_ready_i;
  assign in_stall_o = valid_q && !core_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q <= hdr_i;
    end
  end

  assign hdr_valid_o = valid_q;
  assign hdr_o       = hdr_q;

endmodule

FILE: hw/rtl/msr_core.sv
// msr_core: relocation logic, running positions and result register
// one header per cycle when not stalled, input register to result register; uses msr_pkg
module msr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msr_pkg::cfg_t    cfg_i,
  input  logic             hdr_valid_i,
  input  msr_pkg::header_t hdr_i,
  output logic             core_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output msr_pkg::result_t res_o
);
  import msr_pkg::*;

  // running state
  logic [AddrBits-1:0] src_q, src_d;
  logic [AddrBits-1:0] dst_q, dst_d;
  logic                trunc_q, trunc_d;
  logic                abort_q, abort_d;
  logic                out_valid_q;
  result_t             res_q, res_d;
  logic                take;

  // effective state on entry
  logic [CalcBits-1:0] sds_w, dbase_w;
  logic [AddrBits-1:0] src_e, dst_e;
  logic                trunc_e, abort_e;
  logic [CalcBits-1:0] src_w, dst_w, fs_w, ram_w, avail_w;

  // length and fit
  logic [16:0]         req_bytes, bytes;
  logic                trunc_now;
  logic [CalcBits-1:0] dst_sum, src_sum;
  logic                no_fit;

  // loop
  logic [16:0]         loff, rem;
  logic [17:0]         loop_end;
  logic                no_loop, loop_past;
  logic [15:0]         rlen_cut;
  logic [CalcBits-1:0] loop_sum;

  assign core_ready_o = !out_valid_q || !out_stall_i;
  assign take         = hdr_valid_i && core_ready_o;

  // state on entry, restarted by the first sample of a module
  assign sds_w   = CalcBits'(cfg_i.sample_data_start);
  assign dbase_w = CalcBits'(cfg_i.dest_base);
  assign src_e   = hdr_i.first_sample ? sds_w[AddrBits-1:0] : src_q;
  assign dst_e   = hdr_i.first_sample ? dbase_w[AddrBits-1:0] : dst_q;
  assign trunc_e = hdr_i.first_sample ? 1'b0 : trunc_q;
  assign abort_e = hdr_i.first_sample ? 1'b0 : abort_q;

  assign src_w = CalcBits'(src_e);
  assign dst_w = CalcBits'(dst_e);
  assign fs_w  = CalcBits'(cfg_i.file_size);
  assign ram_w = CalcBits'(cfg_i.ram_size);

  // clamp to the file bytes left
  assign avail_w   = (src_w < fs_w) ? (fs_w - src_w) : '0;
  assign req_bytes = {hdr_i.length_words, 1'b0};
  assign trunc_now = CalcBits'(req_bytes) > avail_w;
  assign bytes     = trunc_now ? avail_w[16:0] : req_bytes;

  // card ram fit check at full precision
  assign dst_sum = dst_w + CalcBits'(bytes);
  assign src_sum = src_w + CalcBits'(bytes);
  assign no_fit  = dst_sum > ram_w;

  // loop start in bytes, then empty and past-end checks
  assign loff = cfg_i.fifteen_sample_mode ? {1'b0, hdr_i.loop_offset_raw[15:1], 1'b0}
                                          : {hdr_i.loop_offset_raw, 1'b0};
  assign no_loop   = (hdr_i.loop_length_words <= 16'd1) || (loff >= bytes);
  assign loop_end  = {1'b0, loff} + {1'b0, hdr_i.loop_length_words, 1'b0};
  assign loop_past = loop_end > {1'b0, bytes};
  assign rem       = bytes - loff;
  assign rlen_cut  = loop_past ? rem[16:1] : hdr_i.loop_length_words;
  assign loop_sum  = dst_w + CalcBits'(loff);

  // result and next state
  always_comb begin
    src_d   = src_e;
    dst_d   = dst_e;
    trunc_d = trunc_e;
    abort_d = abort_e;

    res_d.sample_address   = dst_w[23:0];
    res_d.source_offset    = src_w[23:0];
    res_d.length_out_words = 16'd0;
    res_d.loop_address     = cfg_i.null_loop_address;
    res_d.loop_length_out  = 16'd1;
    res_d.finetune         = 4'd0;
    res_d.volume           = 7'd0;
    res_d.copy_bytes       = 17'd0;
    res_d.status           = ST_ABORTED;

    if (!abort_e) begin
      trunc_d = trunc_e || trunc_now;
      if (no_fit) begin
        abort_d      = 1'b1;
        res_d.status = ST_NO_FIT;
      end else begin
        res_d.status           = ST_OK;
        res_d.length_out_words = bytes[16:1];
        res_d.finetune         = 4'(hdr_i.finetune_byte & FinetuneMask);
        res_d.volume           = (hdr_i.volume_byte > VolumeMax) ? VolumeMax[6:0]
                                                                 : hdr_i.volume_byte[6:0];
        res_d.copy_bytes       = bytes;
        if (!no_loop) begin
          res_d.loop_address    = loop_sum[23:0];
          res_d.loop_length_out = (rlen_cut == 16'd0) ? 16'd1 : rlen_cut;
        end
        src_d = src_sum[AddrBits-1:0];
        dst_d = dst_sum[AddrBits-1:0];
      end
    end

    res_d.truncated  = trunc_d;
    res_d.bytes_used = dst_d - cfg_i.dest_base;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      dst_q       <= '0;
      trunc_q     <= 1'b0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        src_q       <= src_d;
        dst_q       <= dst_d;
        trunc_q     <= trunc_d;
        abort_q     <= abort_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/mod_sample_relocator.sv
// mod_sample_relocator: places tracker sample headers into card sample RAM
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample header request.
//   Output channel (out_valid_o / out_stall_i) returns one result per header:
//   card and file addresses, clamped length, loop address and length,
//   finetune, volume, sticky truncation flag, status and card bytes used.
//   A request moves when valid is high and stall is low at a clock edge.
//   An accepted request is held in the input register, then passes through
//   the relocation logic into the result register, where it can be taken.
//   Throughput is one header per cycle while the receiver does not stall;
//   the running positions are updated in the same cycle that computes a
//   header, so consecutive headers chain. When the receiver stalls, the
//   result register holds, the input register fills, and then in_stall_o
//   rises until the result is taken. Reset (rst_ni low) clears positions
//   and flags, empties both registers and loads the configuration defaults.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the block is idle; the user must ensure this, it is not enforced.
// Depends on msr_pkg, msr_cfg_regs, msr_in_reg, msr_core.
module mod_sample_relocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [msr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [msr_pkg::CfgDataBits-1:0] cfg_wdata_i,
  // header input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            first_sample_i,
  input  logic [15:0]                     length_words_i,
  input  logic [7:0]                      finetune_byte_i,
  input  logic [7:0]                      volume_byte_i,
  input  logic [15:0]                     loop_offset_raw_i,
  input  logic [15:0]                     loop_length_words_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [23:0]                     sample_address_o,
  output logic [15:0]                     length_out_words_o,
  output logic [23:0]                     loop_address_o,
  output logic [15:0]                     loop_length_out_o,
  output logic [3:0]                      finetune_o,
  output logic [6:0]                      volume_o,
  output logic [23:0]                     source_offset_o,
  output logic [16:0]                     copy_bytes_o,
  output logic                            truncated_o,
  output logic [1:0]                      status_o,
  output logic [23:0]                     bytes_used_o
);
  import msr_pkg::*;

  cfg_t    cfg;
  header_t hdr_in;
  header_t hdr;
  logic    hdr_valid;
  logic    core_ready;
  result_t res;

  // pack the header request
  assign hdr_in.first_sample      = first_sample_i;
  assign hdr_in.length_words      = length_words_i;
  assign hdr_in.finetune_byte     = finetune_byte_i;
  assign hdr_in.volume_byte       = volume_byte_i;
  assign hdr_in.loop_offset_raw   = loop_offset_raw_i;
  assign hdr_in.loop_length_words = loop_length_words_i;

  msr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hdr_i        (hdr_in),
    .core_ready_i (core_ready),
    .hdr_valid_o  (hdr_valid),
    .hdr_o        (hdr)
  );

  msr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .hdr_valid_i  (hdr_valid),
    .hdr_i        (hdr),
    .core_ready_o (core_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // unpack the result
  assign sample_address_o   = res.sample_address;
  assign length_out_words_o = res.length_out_words;
  assign loop_address_o     = res.loop_address;
  assign loop_length_out_o  = res.loop_length_out;
  assign finetune_o         = res.finetune;
  assign volume_o           = res.volume;
  assign source_offset_o    = res.source_offset;
  assign copy_bytes_o       = res.copy_bytes;
  assign truncated_o        = res.truncated;
  assign status_o           = res.status;
  assign bytes_used_o       = res.bytes_used;

endmodule
